/* src/cfmb_pkg.sv */
// ============================================================================
// cfmb_pkg
// Shared types and constants for the cluster flow matrix and bound block.
// ============================================================================
package cfmb_pkg;

    localparam int FLOW_W  = 28;
    localparam int BOUND_W = 20;
    localparam int CFG_W   = 7;

    localparam logic [FLOW_W-1:0]  FLOW_MAX    = 28'hFFF_FFFF;
    localparam logic [BOUND_W-1:0] BOUND_LIMIT = 20'd655360;

    localparam logic [6:0] BINS_USED_RST     = 7'd64;
    localparam logic [3:0] CLUSTERS_USED_RST = 4'd8;

    typedef enum logic [1:0] {
        CFG_BINS_USED     = 2'd0,
        CFG_CLUSTERS_USED = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        FUNC_WEIGHT  = 2'd0,
        FUNC_ASSIGN  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  row_index;
        logic [5:0]  col_index;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         from_cluster;
        logic [2:0]         to_cluster;
        logic [FLOW_W-1:0]  flow;
        logic [BOUND_W-1:0] bound;
        logic               last;
    } t_out_item;

endpackage

/* src/cluster_flow_matrix_and_bound.sv */
// ============================================================================
// cluster_flow_matrix_and_bound
// Loads a bin transition weight matrix and a bin-to-cluster assignment, then
// emits the cluster flow matrix row-major with the least asymmetry bound.
// ============================================================================
// A weight load item is written straight into the weight memory, and an
// assignment load item passes through S_ASSIGN, as the assignment row is
// read, merged and written back. A compute item walks every cluster pair
// with one shared saturating accumulator: for each pair, every bin row
// reads its assignment (S_ROW, S_ROWW), and a row whose bin belongs to the
// source cluster then streams its weights, one a cycle, from the weight
// memory (S_COL, S_DRAIN). Each pair ends by storing the flow (S_DONE) and
// updating the bound (S_BEST), and then waits until its result item is
// taken. The assignment store needs no clearing pass after reset.
module cluster_flow_matrix_and_bound
    import cfmb_pkg::*;
#(
    parameter int MAX_BINS     = 64,
    parameter int MAX_CLUSTERS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int BC_W  = $clog2(MAX_BINS + 1);
    localparam int WA_W  = $clog2(MAX_BINS * MAX_BINS);
    localparam int CL_W  = $clog2(MAX_CLUSTERS);
    localparam int CC_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int FA_W  = $clog2(MAX_CLUSTERS * MAX_CLUSTERS);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ASSIGN = 9'b000000010,
        S_ROW    = 9'b000000100,
        S_ROWW   = 9'b000001000,
        S_COL    = 9'b000010000,
        S_DRAIN  = 9'b000100000,
        S_DONE   = 9'b001000000,
        S_BEST   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state;

    logic [6:0]              r_bins_used;
    logic [3:0]              r_clusters_used;
    logic [BC_W-1:0]         r_nb;
    logic [CC_W-1:0]         r_nc;
    logic [BC_W-1:0]         r_i;
    logic [BC_W-1:0]         r_j;
    logic [WA_W-1:0]         r_wbase;
    logic [CL_W-1:0]         r_k;
    logic [CL_W-1:0]         r_l;
    logic [FLOW_W-1:0]       r_acc;
    logic [FLOW_W-1:0]       r_diff;
    logic                    r_chk;
    logic [BOUND_W-1:0]      r_best;
    logic                    r_pv;
    logic [MAX_BINS-1:0]     r_avld;
    logic                    r_avrd;
    logic [BIN_W-1:0]        r_row;
    logic [CL_W-1:0]         r_col;
    logic                    r_bit;
    logic                    r_out_vld;
    t_out_item               r_out;

    logic                    in_acc;
    logic                    in_row_ok;
    logic                    in_wcol_ok;
    logic                    in_ccol_ok;
    logic [BC_W-1:0]         nb_clamp;
    logic [CC_W-1:0]         nc_clamp;
    logic                    w_we;
    logic [WA_W-1:0]         w_waddr;
    logic [WA_W-1:0]         w_raddr;
    logic [15:0]             w_rdata;
    logic                    a_we;
    logic [BIN_W-1:0]        a_raddr;
    logic [MAX_CLUSTERS-1:0] a_rdata;
    logic [MAX_CLUSTERS-1:0] a_row;
    logic [MAX_CLUSTERS-1:0] a_merged;
    logic                    f_we;
    logic [FA_W-1:0]         f_waddr;
    logic [FA_W-1:0]         f_raddr;
    logic [FLOW_W-1:0]       f_rdata;
    logic [FLOW_W:0]         acc_sum;
    logic [FLOW_W-1:0]       acc_sat;
    logic [BC_W-1:0]         i_next;
    logic                    pair_last;
    logic [BOUND_W-1:0]      n_best;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_row_ok  = 32'(i_in_data.row_index) < 32'(MAX_BINS);
    assign in_wcol_ok = 32'(i_in_data.col_index) < 32'(MAX_BINS);
    assign in_ccol_ok = 32'(i_in_data.col_index) < 32'(MAX_CLUSTERS);

    always_comb begin
        if (r_bins_used == 7'd0) begin
            nb_clamp = BC_W'(1);
        end else if (32'(r_bins_used) > 32'(MAX_BINS)) begin
            nb_clamp = BC_W'(MAX_BINS);
        end else begin
            nb_clamp = BC_W'(r_bins_used);
        end
        if (r_clusters_used == 4'd0) begin
            nc_clamp = CC_W'(1);
        end else if (32'(r_clusters_used) > 32'(MAX_CLUSTERS)) begin
            nc_clamp = CC_W'(MAX_CLUSTERS);
        end else begin
            nc_clamp = CC_W'(r_clusters_used);
        end
    end

    // Weight memory.
    assign w_we    = in_acc && (i_in_data.func == FUNC_WEIGHT) && in_row_ok && in_wcol_ok;
    assign w_waddr = WA_W'(i_in_data.row_index) * WA_W'(MAX_BINS)
                   + WA_W'(i_in_data.col_index);
    assign w_raddr = r_wbase + WA_W'(r_j);

    cfmb_ram #(
        .DATA_W (16),
        .DEPTH  (MAX_BINS * MAX_BINS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Assignment memory; a row that has never been written reads as zero.
    always_comb begin
        unique case (r_state)
            S_IDLE:  a_raddr = BIN_W'(i_in_data.row_index);
            S_ROW:   a_raddr = r_i[BIN_W-1:0];
            default: a_raddr = r_j[BIN_W-1:0];
        endcase
    end

    assign a_we  = (r_state == S_ASSIGN);
    assign a_row = r_avrd ? a_rdata : '0;

    always_comb begin
        a_merged        = a_row;
        a_merged[r_col] = r_bit;
    end

    cfmb_ram #(
        .DATA_W (MAX_CLUSTERS),
        .DEPTH  (MAX_BINS)
    ) u_assign_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_row),
        .i_wdata (a_merged),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    // Flow memory; the transposed entry is read throughout each pair.
    assign f_we    = (r_state == S_DONE);
    assign f_waddr = FA_W'(r_k) * FA_W'(MAX_CLUSTERS) + FA_W'(r_l);
    assign f_raddr = FA_W'(r_l) * FA_W'(MAX_CLUSTERS) + FA_W'(r_k);

    cfmb_ram #(
        .DATA_W (FLOW_W),
        .DEPTH  (MAX_CLUSTERS * MAX_CLUSTERS)
    ) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (r_acc),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    assign acc_sum   = {1'b0, r_acc} + (FLOW_W + 1)'(w_rdata);
    assign acc_sat   = acc_sum[FLOW_W] ? FLOW_MAX : acc_sum[FLOW_W-1:0];
    assign i_next    = r_i + BC_W'(1);
    assign pair_last = (CC_W'(r_k) == r_nc - CC_W'(1)) && (CC_W'(r_l) == r_nc - CC_W'(1));

    always_comb begin
        n_best = r_best;
        if (r_chk && (r_diff != '0) && (r_diff < FLOW_W'(r_best))) begin
            n_best = r_diff[BOUND_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_avrd <= r_avld[a_raddr];

        if (r_pv && a_row[r_l]) begin
            r_acc <= acc_sat;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_row   <= BIN_W'(i_in_data.row_index);
                    r_col   <= CL_W'(i_in_data.col_index);
                    r_bit   <= i_in_data.value[0];
                    r_nb    <= nb_clamp;
                    r_nc    <= nc_clamp;
                    r_k     <= '0;
                    r_l     <= '0;
                    r_i     <= '0;
                    r_wbase <= '0;
                    r_acc   <= '0;
                    r_best  <= BOUND_LIMIT;
                end
            end
            S_ROWW: begin
                r_j <= '0;
                if (!a_row[r_k]) begin
                    r_i     <= i_next;
                    r_wbase <= r_wbase + WA_W'(MAX_BINS);
                end
            end
            S_COL: begin
                r_j <= r_j + BC_W'(1);
            end
            S_DRAIN: begin
                r_i     <= i_next;
                r_wbase <= r_wbase + WA_W'(MAX_BINS);
            end
            S_DONE: begin
                r_diff <= (r_acc > f_rdata) ? (r_acc - f_rdata) : (f_rdata - r_acc);
                r_chk  <= (r_l < r_k);
                r_out.from_cluster <= 3'(r_k);
                r_out.to_cluster   <= 3'(r_l);
                r_out.flow         <= r_acc;
                r_out.bound        <= '0;
                r_out.last         <= pair_last;
            end
            S_BEST: begin
                r_best <= n_best;
                if (r_out.last) begin
                    r_out.bound <= (n_best == BOUND_LIMIT) ? '0 : n_best;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    r_i     <= '0;
                    r_wbase <= '0;
                    r_acc   <= '0;
                    if (CC_W'(r_l) == r_nc - CC_W'(1)) begin
                        r_l <= '0;
                        r_k <= r_k + CL_W'(1);
                    end else begin
                        r_l <= r_l + CL_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_bins_used     <= BINS_USED_RST;
            r_clusters_used <= CLUSTERS_USED_RST;
            r_avld          <= '0;
            r_pv            <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_BINS_USED)) begin
                r_bins_used <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_CLUSTERS_USED)) begin
                r_clusters_used <= i_cfg_data[3:0];
            end
            if (a_we) begin
                r_avld[r_row] <= 1'b1;
            end
            r_pv <= (r_state == S_COL);

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.func)
                            FUNC_ASSIGN: begin
                                if (in_row_ok && in_ccol_ok) begin
                                    r_state <= S_ASSIGN;
                                end
                            end
                            FUNC_COMPUTE: r_state <= S_ROW;
                            default:      r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ASSIGN: r_state <= S_IDLE;
                S_ROW:    r_state <= S_ROWW;
                S_ROWW: begin
                    if (a_row[r_k]) begin
                        r_state <= S_COL;
                    end else begin
                        r_state <= (i_next == r_nb) ? S_DONE : S_ROW;
                    end
                end
                S_COL: begin
                    if (r_j + BC_W'(1) == r_nb) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= (i_next == r_nb) ? S_DONE : S_ROW;
                S_DONE:  r_state <= S_BEST;
                S_BEST: begin
                    r_state   <= S_OUT;
                    r_out_vld <= 1'b1;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_vld <= 1'b0;
                        r_state   <= r_out.last ? S_IDLE : S_ROW;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* src/cfmb_ram.sv */
// ============================================================================
// cfmb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module cfmb_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
